// ===== hw/rtl/c_escape_sequence_decoder_macros.svh =====
// Assertion helpers for the escape decoder; every use sits in a module
// that has i_clk and i_rst_n.
`ifndef C_ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CESD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CESD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cesd_pkg.sv =====
`default_nettype none

package cesd_pkg;

    localparam int LENGTH_BITS  = 16;
    localparam int LEN_OUT_BITS = 16;
    localparam int EXT_BITS     = LENGTH_BITS + LEN_OUT_BITS;
    localparam int QDEPTH       = 2;
    localparam int QPTR_BITS    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] ESC_CODE  = 8'h1B;

    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    typedef logic [LENGTH_BITS-1:0]  t_count;
    typedef logic [LEN_OUT_BITS-1:0] t_len;
    typedef logic [EXT_BITS-1:0]     t_len_ext;
    typedef logic [QPTR_BITS-1:0]    t_qptr;
    typedef logic [QCNT_BITS-1:0]    t_qcnt;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_OCT,
        PH_HEX
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BYTE,
        ACT_END
    } t_act;

    // One queue entry: an optional pending number byte, then one action.
    typedef struct packed {
        logic       has_num;
        logic [7:0] num_val;
        t_act       act;
        logic [7:0] act_val;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_named;

    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[8'h30:8'h39]}) begin
            d.val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            d.val = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            d.val = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic t_named named_escape(input logic [7:0] c);
        t_named n;
        n.hit  = 1'b1;
        n.code = '0;
        case (c)
            8'h61: n.code = 8'h07;
            8'h62: n.code = 8'h08;
            8'h65: n.code = ESC_CODE;
            8'h66: n.code = 8'h0C;
            8'h6E: n.code = 8'h0A;
            8'h72: n.code = 8'h0D;
            8'h74: n.code = 8'h09;
            8'h76: n.code = 8'h0B;
            default: n.hit = 1'b0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cesd_ifs.sv =====
`default_nettype none

interface cesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface cesd_out_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     char_out;
    logic                           is_end;
    logic [cesd_pkg::LEN_OUT_BITS-1:0] decoded_length;
    logic                           last;

    modport source (output valid, output char_out, output is_end,
                    output decoded_length, output last, input ready);
    modport sink   (input valid, input char_out, input is_end,
                    input decoded_length, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cesd_queue.sv =====
`default_nettype none

`include "c_escape_sequence_decoder_macros.svh"

module cesd_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  cesd_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output cesd_pkg::t_cmd   o_head,
    output logic             o_nonempty
);

    cesd_pkg::t_cmd  r_mem [cesd_pkg::QDEPTH];
    cesd_pkg::t_qptr r_wr_ptr, n_wr_ptr;
    cesd_pkg::t_qptr r_rd_ptr, n_rd_ptr;
    cesd_pkg::t_qcnt r_count, n_count;

    function automatic cesd_pkg::t_qptr ptr_inc(input cesd_pkg::t_qptr p);
        return (p == cesd_pkg::t_qptr'(cesd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full     = (r_count == cesd_pkg::t_qcnt'(cesd_pkg::QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `CESD_ASSERT_ALWAYS(a_count_bound, r_count <= cesd_pkg::t_qcnt'(cesd_pkg::QDEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== hw/rtl/cesd_front.sv =====
`default_nettype none

`include "c_escape_sequence_decoder_macros.svh"

module cesd_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    cesd_in_if.sink         i_in,
    input  wire             i_full,
    output logic            o_push,
    output cesd_pkg::t_cmd  o_cmd
);

    cesd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_num, n_num;
    logic [1:0]       r_dig, n_dig;

    logic             w_acc;
    logic [7:0]       w_c;
    cesd_pkg::t_digit w_digit;
    cesd_pkg::t_named w_named;
    logic             w_is_oct;
    logic             w_base_ok;
    logic [1:0]       w_maxd;
    logic             w_take_digit;
    logic [1:0]       w_dig_inc;
    logic [7:0]       w_num_next;
    logic             w_done;
    logic             w_oct_start;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_c        = i_in.char_in;

    assign w_digit      = cesd_pkg::digit_of(w_c);
    assign w_named      = cesd_pkg::named_escape(w_c);
    assign w_is_oct     = (r_phase == cesd_pkg::PH_OCT);
    assign w_base_ok    = w_digit.ok && (!w_is_oct || !w_digit.val[3]);
    assign w_maxd       = w_is_oct ? cesd_pkg::OCT_DIGITS : cesd_pkg::HEX_DIGITS;
    assign w_take_digit = w_base_ok && (r_dig < w_maxd);
    assign w_dig_inc    = r_dig + 2'd1;
    assign w_num_next   = w_is_oct ? {r_num[4:0], w_digit.val[2:0]} : {r_num[3:0], w_digit.val};
    assign w_done       = (w_dig_inc >= w_maxd);
    assign w_oct_start  = w_c inside {[8'h30:8'h37]};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            cesd_pkg::PH_TEXT: begin
                n_phase = (w_c == cesd_pkg::CH_BSLASH) ? cesd_pkg::PH_ESC : cesd_pkg::PH_TEXT;
            end
            cesd_pkg::PH_ESC: begin
                if (w_c == cesd_pkg::CH_X) begin
                    n_phase = cesd_pkg::PH_HEX;
                end else if (w_oct_start) begin
                    n_phase = cesd_pkg::PH_OCT;
                end else begin
                    n_phase = cesd_pkg::PH_TEXT;
                end
            end
            cesd_pkg::PH_OCT, cesd_pkg::PH_HEX: begin
                if (w_take_digit) begin
                    n_phase = w_done ? cesd_pkg::PH_TEXT : r_phase;
                end else begin
                    n_phase = (w_c == cesd_pkg::CH_BSLASH) ? cesd_pkg::PH_ESC
                                                           : cesd_pkg::PH_TEXT;
                end
            end
            default: n_phase = cesd_pkg::PH_TEXT;
        endcase
    end

    // Command and number state.
    always_comb begin
        o_cmd.has_num = 1'b0;
        o_cmd.num_val = r_num;
        o_cmd.act     = cesd_pkg::ACT_NONE;
        o_cmd.act_val = w_c;
        n_num         = r_num;
        n_dig         = r_dig;
        case (r_phase)
            cesd_pkg::PH_TEXT: begin
                if (w_c == cesd_pkg::CH_NUL) begin
                    o_cmd.act = cesd_pkg::ACT_END;
                end else if (w_c != cesd_pkg::CH_BSLASH) begin
                    o_cmd.act = cesd_pkg::ACT_BYTE;
                end
            end
            cesd_pkg::PH_ESC: begin
                n_num = '0;
                n_dig = '0;
                if (w_c == cesd_pkg::CH_NUL) begin
                    o_cmd.act = cesd_pkg::ACT_END;
                end else if (w_named.hit) begin
                    o_cmd.act     = cesd_pkg::ACT_BYTE;
                    o_cmd.act_val = w_named.code;
                end else if (w_c == cesd_pkg::CH_X) begin
                    o_cmd.act = cesd_pkg::ACT_NONE;
                end else if (w_oct_start) begin
                    n_num = {5'b0, w_c[2:0]};
                    n_dig = 2'd1;
                end else begin
                    o_cmd.act = cesd_pkg::ACT_BYTE;
                end
            end
            cesd_pkg::PH_OCT, cesd_pkg::PH_HEX: begin
                if (w_take_digit) begin
                    if (w_done) begin
                        o_cmd.act     = cesd_pkg::ACT_BYTE;
                        o_cmd.act_val = w_num_next;
                        n_num         = '0;
                        n_dig         = '0;
                    end else begin
                        n_num = w_num_next;
                        n_dig = w_dig_inc;
                    end
                end else begin
                    // Flush the stopped number, then treat the byte as text.
                    o_cmd.has_num = 1'b1;
                    n_num         = '0;
                    n_dig         = '0;
                    if (w_c == cesd_pkg::CH_NUL) begin
                        o_cmd.act = cesd_pkg::ACT_END;
                    end else if (w_c != cesd_pkg::CH_BSLASH) begin
                        o_cmd.act = cesd_pkg::ACT_BYTE;
                    end
                end
            end
            default: begin
                n_num = '0;
                n_dig = '0;
            end
        endcase
    end

    assign o_push = w_acc && (o_cmd.has_num || (o_cmd.act != cesd_pkg::ACT_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cesd_pkg::PH_TEXT;
            r_num   <= '0;
            r_dig   <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_num   <= n_num;
            r_dig   <= n_dig;
        end
    end

    `CESD_ASSERT_IMPL(a_text_no_number, r_phase == cesd_pkg::PH_TEXT || r_phase == cesd_pkg::PH_ESC, r_num == '0 && r_dig == '0, "number state left over outside a number")

endmodule

`default_nettype wire

// ===== hw/rtl/cesd_back.sv =====
`default_nettype none

`include "c_escape_sequence_decoder_macros.svh"

module cesd_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  cesd_pkg::t_cmd  i_head,
    input  wire             i_nonempty,
    output logic            o_pop,
    cesd_out_if.source      o_out
);

    logic                r_valid, n_valid;
    logic                r_second, n_second;
    cesd_pkg::t_count    r_cnt, n_cnt;
    logic [7:0]          r_char;
    logic                r_end;
    cesd_pkg::t_len      r_len;
    logic                r_last;

    logic                w_take;
    logic                w_first_num;
    logic                w_emit_byte;
    logic [7:0]          w_byte;
    logic                w_last;
    cesd_pkg::t_len_ext  w_cnt_ext;
    cesd_pkg::t_len      w_len_sat;

    assign w_take      = i_nonempty && (!r_valid || o_out.ready);
    assign w_first_num = i_head.has_num && !r_second;
    assign w_emit_byte = w_first_num || (i_head.act == cesd_pkg::ACT_BYTE);
    assign w_byte      = w_first_num ? i_head.num_val : i_head.act_val;
    assign w_last      = !w_first_num || (i_head.act == cesd_pkg::ACT_NONE);
    assign o_pop       = w_take && w_last;

    assign w_cnt_ext = cesd_pkg::t_len_ext'(r_cnt);
    assign w_len_sat = (w_cnt_ext > cesd_pkg::t_len_ext'({cesd_pkg::LEN_OUT_BITS{1'b1}}))
                     ? '1 : w_cnt_ext[cesd_pkg::LEN_OUT_BITS-1:0];

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_cnt    = r_cnt;
        if (w_take) begin
            n_valid  = 1'b1;
            n_second = !w_last;
            if (w_emit_byte) begin
                n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
            end else begin
                n_cnt = '0;
            end
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= w_emit_byte ? w_byte : 8'h00;
            r_end  <= !w_emit_byte;
            r_len  <= w_emit_byte ? '0 : w_len_sat;
            r_last <= w_last;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.char_out       = r_char;
    assign o_out.is_end         = r_end;
    assign o_out.decoded_length = r_len;
    assign o_out.last           = r_last;

    `CESD_ASSERT_IMPL(a_second_half, r_second, i_nonempty && i_head.has_num && i_head.act != cesd_pkg::ACT_NONE, "second result with no action pending")
    `CESD_ASSERT_IMPL(a_end_shape, r_valid && r_end, r_last && r_char == 8'h00, "end word not last or carries a byte")

endmodule

`default_nettype wire

// ===== hw/rtl/c_escape_sequence_decoder.sv =====
// An accepted byte passes the queue, then the output register, before its first decoded word.
// One input byte per cycle while the queue is not full; a byte that ends a number and also
// yields its own word gives two; the single output register drains one word a cycle if ready.
// Reset (i_rst_n low, synchronous): text phase, number and length cleared, queue and
// output emptied.
`default_nettype none

module c_escape_sequence_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cesd_in_if.sink     i_in,
    cesd_out_if.source  o_out
);

    // Front to queue: one command word per input byte that yields anything.
    logic           w_push;
    cesd_pkg::t_cmd w_cmd;
    logic           w_full;

    // Queue to back.
    cesd_pkg::t_cmd w_head;
    logic           w_nonempty;
    logic           w_pop;

    // Front: hold escape and number state, classify each byte into a command.
    cesd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // Short queue decouples classification from output stalls.
    cesd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_nonempty)
    );

    // Back: expand each command into one or two words, track the decoded length.
    cesd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_nonempty (w_nonempty),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/cesd_decode_checker.sv =====
module cesd_decode_checker
    import cesd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cesd_in_if   i_in_mon,
    cesd_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_words_due,
    output int   o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] char_out;
        logic       is_end;
        t_len       decoded_length;
        logic       last;
    } t_word;

    // Decoder state as seen from outside
    t_phase     ph;
    logic [7:0] num_acc;
    logic [1:0] num_digits;
    t_count     emitted;

    t_word words_due[$];
    t_word fresh[$];
    int    fails;
    int    checked;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic clear_state();
        ph         = PH_TEXT;
        num_acc    = '0;
        num_digits = '0;
        emitted    = '0;
    endtask

    task automatic emit_char(input logic [7:0] b);
        t_word w;
        w          = '0;
        w.char_out = b;
        fresh.push_back(w);
        if (emitted != '1) emitted++;
    endtask

    task automatic emit_end();
        t_word w;
        w        = '0;
        w.is_end = 1'b1;
        // saturate the count into the output field
        if (64'(emitted) > 64'(t_len'('1))) w.decoded_length = '1;
        else w.decoded_length = t_len'(emitted);
        fresh.push_back(w);
        clear_state();
    endtask

    task automatic text_char(input logic [7:0] c);
        if (c == CH_NUL) begin
            emit_end();
        end else if (c == CH_BSLASH) begin
            ph = PH_ESC;
        end else begin
            emit_char(c);
        end
    endtask

    task automatic escape_char(input logic [7:0] c);
        ph = PH_TEXT;
        case (c)
            CH_NUL: emit_end();  // trailing backslash is dropped
            "a": emit_char(8'h07);
            "b": emit_char(8'h08);
            "e": emit_char(ESC_CODE);
            "f": emit_char(8'h0C);
            "n": emit_char(8'h0A);
            "r": emit_char(8'h0D);
            "t": emit_char(8'h09);
            "v": emit_char(8'h0B);
            CH_X: begin
                ph         = PH_HEX;
                num_acc    = '0;
                num_digits = '0;
            end
            default: begin
                if (c >= "0" && c <= "7") begin
                    ph         = PH_OCT;
                    num_acc    = c - "0";
                    num_digits = 2'd1;
                end else begin
                    emit_char(c);
                end
            end
        endcase
    endtask

    task automatic number_char(input logic [7:0] c);
        int         radix;
        int         d;
        logic [1:0] digit_limit;
        radix       = (ph == PH_OCT) ? 8 : 16;
        digit_limit = (ph == PH_OCT) ? OCT_DIGITS : HEX_DIGITS;
        d           = digit_value(c);
        if (d >= 0 && d < radix && num_digits < digit_limit) begin
            num_acc = 8'(int'(num_acc) * radix + d);
            num_digits++;
            if (num_digits >= digit_limit) begin
                ph = PH_TEXT;
                emit_char(num_acc);
                num_acc    = '0;
                num_digits = '0;
            end
        end else begin
            // flush the pending number, then treat the byte as plain text
            ph = PH_TEXT;
            emit_char(num_acc);
            num_acc    = '0;
            num_digits = '0;
            text_char(c);
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        fresh.delete();
        case (ph)
            PH_TEXT: text_char(c);
            PH_ESC:  escape_char(c);
            default: number_char(c);
        endcase
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
        foreach (fresh[i]) words_due.push_back(fresh[i]);
    endtask

    always @(posedge i_clk) begin : watch
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            clear_state();
            words_due.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) predict_byte(i_in_mon.char_in);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.char_out       = i_out_mon.char_out;
                got.is_end         = i_out_mon.is_end;
                got.decoded_length = i_out_mon.decoded_length;
                got.last           = i_out_mon.last;
                checked++;
                if (words_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected word: char %02h end %0b len %0d last %0b",
                                 $realtime, got.char_out, got.is_end, got.decoded_length,
                                 got.last);
                end else begin
                    want = words_due.pop_front();
                    if (got.char_out !== want.char_out || got.is_end !== want.is_end ||
                        got.decoded_length !== want.decoded_length ||
                        got.last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: mismatch: expected char %02h end %0b len %0d ",
                                      "last %0b, got char %02h end %0b len %0d last %0b"},
                                     $realtime, want.char_out, want.is_end,
                                     want.decoded_length, want.last, got.char_out,
                                     got.is_end, got.decoded_length, got.last);
                    end
                end
            end
        end
        o_fail_count    <= fails;
        o_words_due     <= words_due.size();
        o_words_checked <= checked;
    end

endmodule

// ===== dv/c_escape_sequence_decoder_test.sv =====
module c_escape_sequence_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cesd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cesd_in_if  in_ch ();
    cesd_out_if out_ch ();

    c_escape_sequence_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    int fail_count;
    int words_due;
    int words_checked;

    // Predict and compare every decoded word beside the block
    cesd_decode_checker decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due),
        .o_words_checked (words_checked)
    );

    // Knobs shared by the byte sender and the word receiver
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_req  = 1'b0;
    int bytes_sent;
    int strings_sent;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one byte, idling a random number of cycles first, and hold it until taken.
    // Valid stays high across back-to-back bytes so it is never dropped and raised
    // in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Any byte except the terminator and the backslash
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CH_BSLASH) c = "A";
        return c;
    endfunction

    // One piece of a string: mostly well-formed escapes with random content,
    // plus digits and raw bytes that break or follow numbers
    task automatic send_piece();
        string named;
        string hexes;
        int    n;
        named = "abefnrtv";
        hexes = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 9))
            0, 1, 2: send_byte(plain_char());
            3: begin
                send_byte(CH_BSLASH);
                send_byte(named[$urandom_range(0, 7)]);
            end
            4: begin
                // octal: one to three digits, sometimes cut short by a non-octal digit
                send_byte(CH_BSLASH);
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'("0" + $urandom_range(0, 7)));
                if (n < 3 && $urandom_range(0, 1)) send_byte(hexes[$urandom_range(8, 21)]);
            end
            5: begin
                // hex: zero to two digits
                send_byte(CH_BSLASH);
                send_byte(CH_X);
                n = $urandom_range(0, 2);
                repeat (n) send_byte(hexes[$urandom_range(0, 21)]);
            end
            6: begin
                send_byte(CH_BSLASH);
                send_byte(8'($urandom_range(1, 255)));
            end
            7: begin
                send_byte(CH_BSLASH);
                send_byte(CH_BSLASH);
            end
            8: send_byte(hexes[$urandom_range(0, 21)]);
            default: send_byte(8'($urandom_range(1, 255)));
        endcase
    endtask

    task automatic send_string(input int pieces);
        repeat (pieces) send_piece();
        // sometimes leave a dangling backslash for the terminator to drop
        if ($urandom_range(0, 7) == 0) send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        strings_sent++;
    endtask

    // Receiver: stall a random number of cycles before each word; on request
    // hold off for a long stretch so the decoder backs up into its input
    initial begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 300;
            end else begin
                stall = stalls_on ? $urandom_range(0, 17) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        bit pressure;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.char_in <= '0;
        bytes_sent    = 0;
        strings_sent  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: named escape, octal that wraps past 255, octal stopped by a
        // non-octal byte, full hex, hex with no digits, plain escaped byte,
        // byte extremes, a dangling backslash, and hex pending at the terminator
        send_text("\\n\\777\\7z\\x4F\\xg\\q");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        send_text("\\x");
        send_byte(CH_NUL);
        strings_sent += 3;

        // Random strings, with stretches where one or both sides never idle
        while (bytes_sent < 520) begin
            pressure  = (strings_sent == 8);
            gaps_on   = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
            stalls_on = $urandom_range(0, 3) != 0;
            if (pressure) begin
                // receiver holds off while bytes keep coming
                hold_req = 1'b1;
                send_string(40);
            end else begin
                send_string($urandom_range(0, 16));
            end
        end

        in_ch.valid <= 1'b0;
        // let the pending count catch up with the last accepted byte
        repeat (2) @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        // allow for anything the block might still emit
        repeat (10) @(posedge i_clk);

        $display("Sent %0d strings, %0d bytes; checked %0d decoded words.",
                 strings_sent, bytes_sent, words_checked);
        $display("Run included random idling and a 300-cycle output hold-off.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
